FILE: rtl/core/plf_pkg.sv
// Shared types, constants and helper functions of the Playfair digraph cipher.
package plf_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = SIDE * SIDE;
    localparam int LETTERS = 26;

    localparam logic [4:0] UNPLACED = 5'd31;
    localparam logic [4:0] LET_X    = 5'd23;
    localparam logic [4:0] LET_J    = 5'd9;
    localparam logic [4:0] LET_I    = 5'd8;
    localparam logic [6:0] ASCII_A  = 7'h41;

    typedef enum logic [1:0] {
        CMD_KEY_CHAR  = 2'd0,
        CMD_KEY_END   = 2'd1,
        CMD_TEXT_CHAR = 2'd2,
        CMD_TEXT_END  = 2'd3
    } cmd_t;

    // One request to a table memory: clear, one write port and two read ports.
    typedef struct packed {
        logic       clear;
        logic       we;
        logic [4:0] waddr;
        logic [4:0] wdata;
        logic       re;
        logic [4:0] raddr_a;
        logic [4:0] raddr_b;
    } mem_req_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } fold_t;

    // Maps an ASCII byte to a letter index, upper-casing and folding J onto I.
    function automatic fold_t fold_letter(logic [7:0] ch);
        fold_t f;
        f.ok  = 1'b0;
        f.idx = '0;
        if (ch inside {[8'h41:8'h5A]}) begin
            f.ok  = 1'b1;
            f.idx = 5'(ch - 8'h41);
        end
        else if (ch inside {[8'h61:8'h7A]}) begin
            f.ok  = 1'b1;
            f.idx = 5'(ch - 8'h61);
        end
        if (f.idx == LET_J) begin
            f.idx = LET_I;
        end
        return f;
    endfunction

    // Cell of a letter in the plain alphabet square; J has no cell.
    function automatic logic [4:0] pos_default(logic [4:0] let_idx);
        logic [4:0] p;
        if (let_idx < LET_J) begin
            p = let_idx;
        end
        else if (let_idx == LET_J) begin
            p = UNPLACED;
        end
        else begin
            p = let_idx - 5'd1;
        end
        return p;
    endfunction

    // Letter held by a cell of the plain alphabet square.
    function automatic logic [4:0] sq_default(logic [4:0] slot);
        logic [4:0] l;
        if (slot < LET_J) begin
            l = slot;
        end
        else begin
            l = slot + 5'd1;
        end
        return l;
    endfunction

    function automatic logic [4:0] wrap_cells(logic [4:0] p);
        logic [4:0] w;
        if (p >= 5'(CELLS)) begin
            w = p - 5'(CELLS);
        end
        else begin
            w = p;
        end
        return w;
    endfunction

    function automatic logic [2:0] row_of(logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end
        else if (p >= 5'd15) begin
            r = 3'd3;
        end
        else if (p >= 5'd10) begin
            r = 3'd2;
        end
        else if (p >= 5'd5) begin
            r = 3'd1;
        end
        else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [4:0] cell_of(logic [2:0] r, logic [2:0] c);
        return 5'(({2'b00, r} << 2) + {2'b00, r} + {2'b00, c});
    endfunction

    function automatic logic [2:0] col_of(logic [4:0] p);
        return 3'(p - cell_of(row_of(p), 3'd0));
    endfunction

    // One step round a row or column: forwards to encrypt, backwards to decrypt.
    function automatic logic [2:0] step5(logic [2:0] v, logic dec);
        logic [2:0] s;
        if (dec) begin
            s = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
        end
        else begin
            s = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
        end
        return s;
    endfunction

endpackage

FILE: rtl/core/plf_if.sv
// Channel interfaces of the Playfair digraph cipher: input, result and configuration.
interface plf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] char_in;

    modport source (output valid, cmd, char_in, input ready);
    modport sink   (input valid, cmd, char_in, output ready);
endinterface

interface plf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] letter_out;
    logic       last_of_pair;

    modport source (output valid, letter_out, last_of_pair, input ready);
    modport sink   (input valid, letter_out, last_of_pair, output ready);
endinterface

interface plf_cfg_if;
    logic valid;
    logic ready;
    logic decrypt_mode;

    modport source (output valid, decrypt_mode, input ready);
    modport sink   (input valid, decrypt_mode, output ready);
endinterface

FILE: rtl/core/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: request sequencer around the two table memories.
//
// The block takes one ASCII byte per request and streams Playfair encryption or
// decryption. Key characters (letters upper-cased, J folded onto I, repeats
// ignored) fill a 5x5 square row by row; a key end, or the first text request
// after an unfinished key, completes it with the unused letters in alphabet
// order. Text letters pair into digraphs, a doubled letter inside a pair is
// split with X, and a text end pads a lone letter with X. Each digraph gives two
// result letters, the second marked by last_of_pair. The square and the
// letter-to-cell table live in two small synchronous memories with registered
// reads; per-entry valid bits stand in for clearing them, so there is no clear
// pass after reset and the block accepts requests as soon as reset ends. A text
// letter that opens a pair, a non-letter, or a key end on a finished square is
// handled in the idle state alone; a key letter takes a read of the letter's
// cell, then the write-back. A text request that completes a digraph goes
// through the request with the cell reads, rule evaluation with the square
// reads, and hand-over to the result buffer, which waits while the buffer drains.
// Completing the square walks all 26 letters through the letter table, a read
// and a write-back each, ahead of the text request that triggered it. The mode
// register is sampled when a digraph is transformed and the configuration
// channel is always ready; it should be written only while the block is idle.
module playfair_digraph_cipher (
    input  logic        clk,
    input  logic        rst_n,
    plf_in_if.sink      in_ch,
    plf_out_if.source   out_ch,
    plf_cfg_if.sink     cfg_ch
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY_CHK,
        S_FILL_RD,
        S_FILL_WR,
        S_TEXT,
        S_POS,
        S_SQ
    } seq_state_t;

    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [4:0]          fill_reg;
    logic [4:0]          fill_next;
    logic                key_done_reg;
    logic                key_done_next;
    logic [4:0]          pend_let_reg;
    logic [4:0]          pend_let_next;
    logic                pend_vld_reg;
    logic                pend_vld_next;
    logic [4:0]          walk_reg;
    logic [4:0]          walk_next;
    logic                text_wait_reg;
    logic                text_wait_next;
    plf_pkg::cmd_t       cur_cmd_reg;
    plf_pkg::cmd_t       cur_cmd_next;
    plf_pkg::fold_t      cur_let_reg;
    plf_pkg::fold_t      cur_let_next;
    logic                mode_reg;

    plf_pkg::mem_req_t   pos_req;
    plf_pkg::mem_req_t   sq_req;
    logic [4:0]          pos_rd_a;
    logic [4:0]          pos_rd_b;
    logic [4:0]          sq_rd_a;
    logic [4:0]          sq_rd_b;
    logic [4:0]          xf_cell_a;
    logic [4:0]          xf_cell_b;
    logic                buf_free;
    logic                buf_load;

    logic                accept;
    plf_pkg::cmd_t       in_cmd;
    plf_pkg::fold_t      in_let;

    // Text step: source of the request and the digraph it produces, if any.
    plf_pkg::cmd_t       tx_cmd;
    plf_pkg::fold_t      tx_let;
    logic                tx_emit;
    logic [4:0]          tx_b;
    logic                tx_pend_vld;
    logic [4:0]          tx_pend_let;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign accept       = in_ch.valid && in_ch.ready;
    assign in_cmd       = plf_pkg::cmd_t'(in_ch.cmd);
    assign in_let       = plf_pkg::fold_letter(in_ch.char_in);
    assign cfg_ch.ready = 1'b1;

    plf_pos_mem u_pos_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pos_req),
        .rd_a  (pos_rd_a),
        .rd_b  (pos_rd_b)
    );

    plf_sq_mem u_sq_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rd_a  (sq_rd_a),
        .rd_b  (sq_rd_b)
    );

    plf_pair_xform u_xform (
        .pos_a   (pos_rd_a),
        .pos_b   (pos_rd_b),
        .decrypt (mode_reg),
        .cell_a  (xf_cell_a),
        .cell_b  (xf_cell_b)
    );

    plf_out_buf u_out_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (buf_load),
        .let_a  (sq_rd_a),
        .let_b  (sq_rd_b),
        .free   (buf_free),
        .out_ch (out_ch)
    );

    // Pairing of text letters. In the idle state the request comes straight
    // from the input channel; after a square completion it comes from the
    // request saved when the completion started.
    always_comb begin
        tx_cmd      = (state_reg == S_IDLE) ? in_cmd : cur_cmd_reg;
        tx_let      = (state_reg == S_IDLE) ? in_let : cur_let_reg;
        tx_emit     = 1'b0;
        tx_b        = plf_pkg::LET_X;
        tx_pend_vld = pend_vld_reg;
        tx_pend_let = pend_let_reg;
        if (tx_cmd == plf_pkg::CMD_TEXT_CHAR && tx_let.ok) begin
            if (!pend_vld_reg) begin
                tx_pend_vld = 1'b1;
                tx_pend_let = tx_let.idx;
            end
            else if (tx_let.idx == pend_let_reg) begin
                // A doubled letter is split with X and stays open for the next pair.
                tx_emit = 1'b1;
            end
            else begin
                tx_emit     = 1'b1;
                tx_b        = tx_let.idx;
                tx_pend_vld = 1'b0;
                tx_pend_let = '0;
            end
        end
        else if (tx_cmd == plf_pkg::CMD_TEXT_END && pend_vld_reg) begin
            tx_emit     = 1'b1;
            tx_pend_vld = 1'b0;
            tx_pend_let = '0;
        end
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        key_done_next  = key_done_reg;
        pend_let_next  = pend_let_reg;
        pend_vld_next  = pend_vld_reg;
        walk_next      = walk_reg;
        text_wait_next = text_wait_reg;
        cur_cmd_next   = cur_cmd_reg;
        cur_let_next   = cur_let_reg;
        pos_req        = '0;
        sq_req         = '0;
        buf_load       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        plf_pkg::CMD_KEY_CHAR: begin
                            if (key_done_reg) begin
                                // A new key starts from an empty square.
                                pos_req.clear = 1'b1;
                                sq_req.clear  = 1'b1;
                                fill_next     = '0;
                                key_done_next = 1'b0;
                                pend_vld_next = 1'b0;
                                pend_let_next = '0;
                            end
                            if (in_let.ok) begin
                                pos_req.re      = 1'b1;
                                pos_req.raddr_a = in_let.idx;
                                pos_req.raddr_b = in_let.idx;
                                cur_let_next    = in_let;
                                state_next      = S_KEY_CHK;
                            end
                        end
                        plf_pkg::CMD_KEY_END: begin
                            if (!key_done_reg) begin
                                walk_next      = '0;
                                text_wait_next = 1'b0;
                                state_next     = S_FILL_RD;
                            end
                        end
                        default: begin
                            if (!key_done_reg) begin
                                // Text before the key end: finish the square first.
                                cur_cmd_next   = in_cmd;
                                cur_let_next   = in_let;
                                walk_next      = '0;
                                text_wait_next = 1'b1;
                                state_next     = S_FILL_RD;
                            end
                            else begin
                                pend_vld_next = tx_pend_vld;
                                pend_let_next = tx_pend_let;
                                if (tx_emit) begin
                                    pos_req.re      = 1'b1;
                                    pos_req.raddr_a = pend_let_reg;
                                    pos_req.raddr_b = tx_b;
                                    state_next      = S_POS;
                                end
                            end
                        end
                    endcase
                end
            end
            S_KEY_CHK: begin
                if (pos_rd_a == plf_pkg::UNPLACED && fill_reg < 5'(plf_pkg::CELLS)) begin
                    sq_req.we     = 1'b1;
                    sq_req.waddr  = fill_reg;
                    sq_req.wdata  = cur_let_reg.idx;
                    pos_req.we    = 1'b1;
                    pos_req.waddr = cur_let_reg.idx;
                    pos_req.wdata = fill_reg;
                    fill_next     = fill_reg + 5'd1;
                end
                state_next = S_IDLE;
            end
            S_FILL_RD: begin
                pos_req.re      = 1'b1;
                pos_req.raddr_a = walk_reg;
                pos_req.raddr_b = walk_reg;
                state_next      = S_FILL_WR;
            end
            S_FILL_WR: begin
                if (walk_reg != plf_pkg::LET_J && pos_rd_a == plf_pkg::UNPLACED &&
                    fill_reg < 5'(plf_pkg::CELLS)) begin
                    sq_req.we     = 1'b1;
                    sq_req.waddr  = fill_reg;
                    sq_req.wdata  = walk_reg;
                    pos_req.we    = 1'b1;
                    pos_req.waddr = walk_reg;
                    pos_req.wdata = fill_reg;
                    fill_next     = fill_reg + 5'd1;
                end
                if (walk_reg == 5'(plf_pkg::LETTERS - 1)) begin
                    key_done_next = 1'b1;
                    state_next    = text_wait_reg ? S_TEXT : S_IDLE;
                end
                else begin
                    walk_next  = walk_reg + 5'd1;
                    state_next = S_FILL_RD;
                end
            end
            S_TEXT: begin
                pend_vld_next = tx_pend_vld;
                pend_let_next = tx_pend_let;
                if (tx_emit) begin
                    pos_req.re      = 1'b1;
                    pos_req.raddr_a = pend_let_reg;
                    pos_req.raddr_b = tx_b;
                    state_next      = S_POS;
                end
                else begin
                    state_next = S_IDLE;
                end
            end
            S_POS: begin
                sq_req.re      = 1'b1;
                sq_req.raddr_a = xf_cell_a;
                sq_req.raddr_b = xf_cell_b;
                state_next     = S_SQ;
            end
            S_SQ: begin
                // The square read data holds until the result buffer has room.
                if (buf_free) begin
                    buf_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            fill_reg      <= 5'(plf_pkg::CELLS);
            key_done_reg  <= 1'b1;
            pend_let_reg  <= '0;
            pend_vld_reg  <= 1'b0;
            walk_reg      <= '0;
            text_wait_reg <= 1'b0;
            cur_cmd_reg   <= plf_pkg::CMD_KEY_CHAR;
            cur_let_reg   <= '0;
            mode_reg      <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            key_done_reg  <= key_done_next;
            pend_let_reg  <= pend_let_next;
            pend_vld_reg  <= pend_vld_next;
            walk_reg      <= walk_next;
            text_wait_reg <= text_wait_next;
            cur_cmd_reg   <= cur_cmd_next;
            cur_let_reg   <= cur_let_next;
            if (cfg_ch.valid && cfg_ch.ready) begin
                mode_reg <= cfg_ch.decrypt_mode;
            end
        end
    end

endmodule

FILE: rtl/core/plf_pos_mem.sv
// Letter-to-cell table: synchronous memory with per-entry valid bits.
module plf_pos_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  plf_pkg::mem_req_t  req,
    output logic [4:0]         rd_a,
    output logic [4:0]         rd_b
);

    logic [4:0]                   mem_reg [plf_pkg::LETTERS];
    logic [plf_pkg::LETTERS-1:0]  vld_reg;
    logic                         base_reg;
    logic [4:0]                   addr_a_reg;
    logic [4:0]                   addr_b_reg;
    logic [4:0]                   data_a_reg;
    logic [4:0]                   data_b_reg;

    always_ff @(posedge clk) begin
        if (req.we) begin
            mem_reg[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            data_a_reg <= mem_reg[req.raddr_a];
            data_b_reg <= mem_reg[req.raddr_b];
            addr_a_reg <= req.raddr_a;
            addr_b_reg <= req.raddr_b;
        end
    end

    // Entries never written since reset read as the alphabet square, and
    // after a clear they read as unplaced.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg  <= '0;
            base_reg <= 1'b1;
        end
        else begin
            if (req.clear) begin
                vld_reg  <= '0;
                base_reg <= 1'b0;
            end
            if (req.we) begin
                vld_reg[req.waddr] <= 1'b1;
            end
        end
    end

    always_comb begin
        if (vld_reg[addr_a_reg]) begin
            rd_a = data_a_reg;
        end
        else begin
            rd_a = base_reg ? plf_pkg::pos_default(addr_a_reg) : plf_pkg::UNPLACED;
        end
        if (vld_reg[addr_b_reg]) begin
            rd_b = data_b_reg;
        end
        else begin
            rd_b = base_reg ? plf_pkg::pos_default(addr_b_reg) : plf_pkg::UNPLACED;
        end
    end

endmodule

FILE: rtl/core/plf_sq_mem.sv
// Key square: synchronous memory of the letter in each cell, with per-entry valid bits.
module plf_sq_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  plf_pkg::mem_req_t  req,
    output logic [4:0]         rd_a,
    output logic [4:0]         rd_b
);

    logic [4:0]                 mem_reg [plf_pkg::CELLS];
    logic [plf_pkg::CELLS-1:0]  vld_reg;
    logic                       base_reg;
    logic [4:0]                 addr_a_reg;
    logic [4:0]                 addr_b_reg;
    logic [4:0]                 data_a_reg;
    logic [4:0]                 data_b_reg;

    always_ff @(posedge clk) begin
        if (req.we) begin
            mem_reg[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            data_a_reg <= mem_reg[req.raddr_a];
            data_b_reg <= mem_reg[req.raddr_b];
            addr_a_reg <= req.raddr_a;
            addr_b_reg <= req.raddr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg  <= '0;
            base_reg <= 1'b1;
        end
        else begin
            if (req.clear) begin
                vld_reg  <= '0;
                base_reg <= 1'b0;
            end
            if (req.we) begin
                vld_reg[req.waddr] <= 1'b1;
            end
        end
    end

    always_comb begin
        if (vld_reg[addr_a_reg]) begin
            rd_a = data_a_reg;
        end
        else begin
            rd_a = base_reg ? plf_pkg::sq_default(addr_a_reg) : 5'd0;
        end
        if (vld_reg[addr_b_reg]) begin
            rd_b = data_b_reg;
        end
        else begin
            rd_b = base_reg ? plf_pkg::sq_default(addr_b_reg) : 5'd0;
        end
    end

endmodule

FILE: rtl/core/plf_pair_xform.sv
// Digraph rules: maps the cells of two letters to the cells of their cipher letters.
module plf_pair_xform (
    input  logic [4:0] pos_a,
    input  logic [4:0] pos_b,
    input  logic       decrypt,
    output logic [4:0] cell_a,
    output logic [4:0] cell_b
);

    logic [4:0] pa;
    logic [4:0] pb;
    logic [2:0] r1;
    logic [2:0] c1;
    logic [2:0] r2;
    logic [2:0] c2;

    always_comb begin
        pa = plf_pkg::wrap_cells(pos_a);
        pb = plf_pkg::wrap_cells(pos_b);
        r1 = plf_pkg::row_of(pa);
        c1 = plf_pkg::col_of(pa);
        r2 = plf_pkg::row_of(pb);
        c2 = plf_pkg::col_of(pb);
        if (r1 == r2) begin
            cell_a = plf_pkg::cell_of(r1, plf_pkg::step5(c1, decrypt));
            cell_b = plf_pkg::cell_of(r2, plf_pkg::step5(c2, decrypt));
        end
        else if (c1 == c2) begin
            cell_a = plf_pkg::cell_of(plf_pkg::step5(r1, decrypt), c1);
            cell_b = plf_pkg::cell_of(plf_pkg::step5(r2, decrypt), c2);
        end
        else begin
            // Rectangle: each letter keeps its row and takes the other's column.
            cell_a = plf_pkg::cell_of(r1, c2);
            cell_b = plf_pkg::cell_of(r2, c1);
        end
    end

endmodule

FILE: rtl/core/plf_out_buf.sv
// Result buffer: holds one transformed digraph and hands it out letter by letter.
module plf_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [4:0]          let_a,
    input  logic [4:0]          let_b,
    output logic                free,
    plf_out_if.source           out_ch
);

    typedef enum logic [1:0] {
        B_EMPTY,
        B_FIRST,
        B_SECOND
    } buf_state_t;

    buf_state_t state_reg;
    buf_state_t state_next;
    logic [6:0] asc_a_reg;
    logic [6:0] asc_b_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_EMPTY: begin
                if (load) begin
                    state_next = B_FIRST;
                end
            end
            B_FIRST: begin
                if (out_ch.ready) begin
                    state_next = B_SECOND;
                end
            end
            B_SECOND: begin
                if (out_ch.ready) begin
                    state_next = B_EMPTY;
                end
            end
            default: begin
                state_next = B_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= B_EMPTY;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load && state_reg == B_EMPTY) begin
            asc_a_reg <= plf_pkg::ASCII_A + {2'b00, let_a};
            asc_b_reg <= plf_pkg::ASCII_A + {2'b00, let_b};
        end
    end

    assign free                = (state_reg == B_EMPTY);
    assign out_ch.valid        = (state_reg != B_EMPTY);
    assign out_ch.letter_out   = (state_reg == B_SECOND) ? asc_b_reg : asc_a_reg;
    assign out_ch.last_of_pair = (state_reg == B_SECOND);

endmodule
